>>> rtl/ilcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilcc_pkg
// Types, constants and helper functions shared by the IPv4 / layer four
// checksum checker.
// ----------------------------------------------------------------------------
package ilcc_pkg;

  localparam int unsigned ILCC_QUEUE_DEPTH = 4;

  // protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_TCP   = 2'd1,
    CLS_UDP   = 2'd2,
    CLS_ICMP  = 2'd3
  } ilcc_cls_t;

  // byte positions inside the ipv4 header
  localparam logic [15:0] POS_IHL        = 16'd0;
  localparam logic [15:0] POS_TOTLEN_HI  = 16'd2;
  localparam logic [15:0] POS_TOTLEN_LO  = 16'd3;
  localparam logic [15:0] POS_PROTO      = 16'd9;
  localparam logic [15:0] POS_HDR_CK_HI  = 16'd10;
  localparam logic [15:0] POS_HDR_CK_LO  = 16'd11;
  localparam logic [15:0] POS_PSEUDO_LO  = 16'd13;
  localparam logic [15:0] POS_PSEUDO_HI  = 16'd19;
  localparam logic [15:0] POS_SATURATE   = 16'hffff;

  localparam logic [5:0]  HDR_MIN_BYTES  = 6'd20;
  localparam logic [15:0] UDP_MIN_LEN    = 16'd8;
  localparam logic [15:0] UDP_LEN_OFFSET = 16'd5;

  // checksum field offsets inside the layer four region
  localparam logic [15:0] CKO_TCP  = 16'd16;
  localparam logic [15:0] CKO_UDP  = 16'd6;
  localparam logic [15:0] CKO_ICMP = 16'd2;

  typedef struct packed {
    logic [15:0] count;
    logic [5:0]  hdr_bytes;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [15:0] udp_len;
    logic [15:0] stored_hdr;
    logic [15:0] stored_pay;
  } ilcc_meta_t;

  // one classified byte, front to back
  typedef struct packed {
    logic        hdr_add;
    logic        pay_add;
    logic        pay_pad;
    logic [15:0] word;
    logic        last;
    ilcc_meta_t  meta;
  } ilcc_op_t;

  // finished sums of one packet
  typedef struct packed {
    logic [15:0] hdr_sum;
    logic [15:0] pay_sum;
    ilcc_meta_t  meta;
  } ilcc_fin_t;

  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[16] ? (t[15:0] + 16'd1) : t[15:0];
  endfunction

  function automatic ilcc_cls_t class_of(input logic [7:0] p);
    ilcc_cls_t c;
    case (p)
      PROTO_TCP:  c = CLS_TCP;
      PROTO_UDP:  c = CLS_UDP;
      PROTO_ICMP: c = CLS_ICMP;
      default:    c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // layer four region starts at the larger of ihl*4 and 20
  function automatic logic [15:0] region_start(input logic [5:0] hb);
    return (hb < HDR_MIN_BYTES) ? {10'd0, HDR_MIN_BYTES} : {10'd0, hb};
  endfunction

endpackage
`default_nettype wire

>>> rtl/ilcc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilcc_if
// Valid/ready channels for packet bytes in and checksum results out.
// ----------------------------------------------------------------------------
interface ilcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ilcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ip_sum;
  logic [15:0] l4_sum;
  logic [1:0]  proto_class;
  logic        ip_ok;
  logic        l4_ok;
  logic        packet_ok;
  logic        truncated;

  modport source (output valid, output ip_sum, output l4_sum, output proto_class,
                  output ip_ok, output l4_ok, output packet_ok, output truncated,
                  input ready);
  modport sink   (input valid, input ip_sum, input l4_sum, input proto_class,
                  input ip_ok, input l4_ok, input packet_ok, input truncated,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/ipv4_l4_checksum_check.sv
`timescale 1ns / 1ps
`default_nettype none
// result path: the last byte of a packet is registered in the byte queue, then in
//   the hand-off register, the first finish stage and the output register
// throughput: one byte per cycle; the parser takes a byte whenever the
//   byte queue has room, at most one ones' complement add per sum and byte in the accumulator
// reset: synchronous active-low rst_n clears position, header fields, sums,
//   queue and all valid flags; the block accepts bytes in the next cycle
// ----------------------------------------------------------------------------
// ipv4_l4_checksum_check
// Byte-serial IPv4 header and TCP/UDP/ICMP checksum checker, one result per
// packet.
// ----------------------------------------------------------------------------
module ipv4_l4_checksum_check #(
  parameter int unsigned QUEUE_DEPTH = ilcc_pkg::ILCC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  ilcc_in_if.sink     in_ch,
  ilcc_out_if.source  out_ch
);
  import ilcc_pkg::*;

  logic      push_valid, push_ready;
  ilcc_op_t  push_op;
  logic      pop_valid, pop_ready;
  ilcc_op_t  pop_op;
  logic      fin_valid, fin_ready;
  ilcc_fin_t fin;

  ilcc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  ilcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  ilcc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (pop_valid),
    .op_ready  (pop_ready),
    .op        (pop_op),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  ilcc_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

>>> rtl/ilcc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilcc_queue
// Short fifo of classified bytes between the parser and the accumulator.
// ----------------------------------------------------------------------------
module ilcc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  ilcc_pkg::ilcc_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ilcc_pkg::ilcc_op_t pop_op
);
  import ilcc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ilcc_op_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_op     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule
`default_nettype wire

>>> rtl/ilcc_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilcc_parse
// Front end: tracks the byte position, picks up header fields and marks
// each byte for the header sum, the layer four sum, both or neither.
// ----------------------------------------------------------------------------
module ilcc_parse (
  input  logic               clk,
  input  logic               rst_n,
  ilcc_in_if.sink            in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output ilcc_pkg::ilcc_op_t push_op
);
  import ilcc_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [5:0]  hb_r, hb_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] udp_r, udp_nxt;
  logic [15:0] shc_r, shc_nxt;
  logic [15:0] spc_r, spc_nxt;

  logic        fire, active, odd;
  logic [15:0] word, start, rel, cko, udp_rlen;
  logic [16:0] udp_end;
  ilcc_cls_t   cls;
  logic        in_region, ck_hi, ck_lo, before_end, at_end;
  logic        hdr_add, pseudo_add, region_add;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign fire        = in_ch.valid && push_ready;

  always_comb begin
    active   = (pos_r != POS_SATURATE);
    odd      = pos_r[0];
    word     = {hold_r, in_ch.data_byte};
    cls      = class_of(proto_r);
    start    = region_start(hb_r);
    rel      = pos_r - start;
    case (cls)
      CLS_TCP: cko = CKO_TCP;
      CLS_UDP: cko = CKO_UDP;
      default: cko = CKO_ICMP;
    endcase
    udp_rlen = (udp_r < UDP_MIN_LEN) ? UDP_MIN_LEN : udp_r;
    udp_end  = {1'b0, start} + {1'b0, udp_rlen};

    // tcp/icmp end is total length, or wraps past 64k when total is short
    if (cls == CLS_UDP) begin
      before_end = ({1'b0, pos_r} < udp_end);
      at_end     = (({1'b0, pos_r} + 17'd1) == udp_end);
    end else begin
      before_end = (tot_r < start) || (pos_r < tot_r);
      at_end     = (tot_r >= start) && ((pos_r + 16'd1) == tot_r);
    end

    in_region  = active && (cls != CLS_OTHER) && (pos_r >= start);
    ck_hi      = in_region && (rel == cko);
    ck_lo      = in_region && (rel == (cko + 16'd1));

    hdr_add    = active && odd && (pos_r < {10'd0, hb_r}) && (pos_r != POS_HDR_CK_LO);
    pseudo_add = active && odd && (pos_r >= POS_PSEUDO_LO) && (pos_r <= POS_PSEUDO_HI)
                 && ((cls == CLS_TCP) || (cls == CLS_UDP));
    region_add = in_region && !ck_hi && !ck_lo && before_end && (odd || at_end);

    hb_nxt    = (active && pos_r == POS_IHL) ? {in_ch.data_byte[3:0], 2'b00} : hb_r;
    tot_nxt   = tot_r;
    if (active && pos_r == POS_TOTLEN_HI) begin
      tot_nxt = {in_ch.data_byte, tot_r[7:0]};
    end else if (active && pos_r == POS_TOTLEN_LO) begin
      tot_nxt = {tot_r[15:8], in_ch.data_byte};
    end
    proto_nxt = (active && pos_r == POS_PROTO) ? in_ch.data_byte : proto_r;
    shc_nxt   = shc_r;
    if (active && pos_r == POS_HDR_CK_HI) begin
      shc_nxt = {in_ch.data_byte, shc_r[7:0]};
    end else if (active && pos_r == POS_HDR_CK_LO) begin
      shc_nxt = {shc_r[15:8], in_ch.data_byte};
    end
    udp_nxt   = (in_region && cls == CLS_UDP && rel == UDP_LEN_OFFSET) ? word : udp_r;
    spc_nxt   = spc_r;
    if (ck_hi) begin
      spc_nxt = {in_ch.data_byte, spc_r[7:0]};
    end else if (ck_lo) begin
      spc_nxt = {spc_r[15:8], in_ch.data_byte};
    end
    hold_nxt  = (active && !odd) ? in_ch.data_byte : hold_r;
    pos_nxt   = active ? pos_r + 16'd1 : pos_r;
  end

  always_comb begin
    push_op.hdr_add         = hdr_add;
    push_op.pay_add         = pseudo_add || region_add;
    push_op.pay_pad         = region_add && !odd;
    push_op.word            = word;
    push_op.last            = in_ch.last;
    push_op.meta.count      = pos_nxt;
    push_op.meta.hdr_bytes  = hb_nxt;
    push_op.meta.total_len  = tot_nxt;
    push_op.meta.proto      = proto_nxt;
    push_op.meta.udp_len    = udp_nxt;
    push_op.meta.stored_hdr = shc_nxt;
    push_op.meta.stored_pay = spc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_ch.last)) begin
      pos_r   <= '0;
      hold_r  <= '0;
      hb_r    <= '0;
      tot_r   <= '0;
      proto_r <= '0;
      udp_r   <= '0;
      shc_r   <= '0;
      spc_r   <= '0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      hold_r  <= hold_nxt;
      hb_r    <= hb_nxt;
      tot_r   <= tot_nxt;
      proto_r <= proto_nxt;
      udp_r   <= udp_nxt;
      shc_r   <= shc_nxt;
      spc_r   <= spc_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last) |=> (pos_r == '0 && proto_r == '0))
    else $error("parser state not cleared after last byte");

endmodule
`default_nettype wire

>>> rtl/ilcc_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilcc_accum
// Back end, first part: ones' complement accumulation of header and layer
// four words, and a hand-off register for the sums of a finished packet.
// ----------------------------------------------------------------------------
module ilcc_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  output logic                op_ready,
  input  ilcc_pkg::ilcc_op_t  op,
  output logic                fin_valid,
  input  logic                fin_ready,
  output ilcc_pkg::ilcc_fin_t fin
);
  import ilcc_pkg::*;

  logic [15:0] hdr_sum_r, hdr_sum_nxt;
  logic [15:0] pay_sum_r, pay_sum_nxt;
  logic [15:0] pay_word;
  logic        fin_v_r;
  ilcc_fin_t   fin_r;
  logic        hold_free, pop;

  assign hold_free = !fin_v_r || fin_ready;
  // only the last byte of a packet needs room in the hand-off register
  assign op_ready  = !op.last || hold_free;
  assign pop       = op_valid && op_ready;
  assign fin_valid = fin_v_r;
  assign fin       = fin_r;

  always_comb begin
    pay_word    = op.pay_pad ? {op.word[7:0], 8'h00} : op.word;
    hdr_sum_nxt = op.hdr_add ? oc_add(hdr_sum_r, op.word) : hdr_sum_r;
    pay_sum_nxt = op.pay_add ? oc_add(pay_sum_r, pay_word) : pay_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_sum_r <= '0;
      pay_sum_r <= '0;
      fin_v_r   <= 1'b0;
    end else begin
      if (pop) begin
        hdr_sum_r <= op.last ? '0 : hdr_sum_nxt;
        pay_sum_r <= op.last ? '0 : pay_sum_nxt;
      end
      if (pop && op.last) begin
        fin_v_r <= 1'b1;
      end else if (fin_ready) begin
        fin_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && op.last) begin
      fin_r.hdr_sum <= hdr_sum_nxt;
      fin_r.pay_sum <= pay_sum_nxt;
      fin_r.meta    <= op.meta;
    end
  end

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && op_ready && op.last) |=> (hdr_sum_r == '0 && pay_sum_r == '0 && fin_v_r))
    else $error("sums not cleared or result not held after last byte");

endmodule
`default_nettype wire

>>> rtl/ilcc_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilcc_finish
// Back end, second part: pseudo header words, truncation check, final
// complement and comparison against the stored checksums.
// ----------------------------------------------------------------------------
module ilcc_finish (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fin_valid,
  output logic                fin_ready,
  input  ilcc_pkg::ilcc_fin_t fin,
  ilcc_out_if.source          out_ch
);
  import ilcc_pkg::*;

  // first stage
  logic        s2_v_r;
  logic [15:0] s2_ip_sum_r, s2_shc_r, s2_spc_r, s2_psum_r, s2_len_r;
  ilcc_cls_t   s2_cls_r;
  logic        s2_pseudo_r, s2_trunc_r;

  // output register
  logic        out_v_r;
  logic [15:0] out_ip_sum_r, out_l4_sum_r;
  ilcc_cls_t   out_cls_r;
  logic        out_ip_ok_r, out_l4_ok_r, out_trunc_r;

  logic        s2_ready, out_free;
  ilcc_cls_t   cls_c;
  logic        pseudo_c, trunc_c;
  logic [15:0] start_c, len_c, rlen_c, psum_c;
  logic [16:0] end_c;
  logic [15:0] l4_raw, l4_sum_c;
  logic        ip_ok_c, l4_ok_c;

  assign out_free  = !out_v_r || out_ch.ready;
  assign s2_ready  = !s2_v_r || out_free;
  assign fin_ready = s2_ready;

  always_comb begin
    cls_c    = class_of(fin.meta.proto);
    pseudo_c = (cls_c == CLS_TCP) || (cls_c == CLS_UDP);
    start_c  = region_start(fin.meta.hdr_bytes);
    len_c    = (cls_c == CLS_UDP) ? fin.meta.udp_len : (fin.meta.total_len - start_c);
    if (cls_c == CLS_UDP && fin.meta.udp_len < UDP_MIN_LEN) begin
      rlen_c = UDP_MIN_LEN;
    end else begin
      rlen_c = len_c;
    end
    end_c    = {1'b0, start_c} + {1'b0, rlen_c};
    psum_c   = pseudo_c ? oc_add(fin.pay_sum, {8'h00, fin.meta.proto}) : fin.pay_sum;
    trunc_c  = (fin.meta.count < {10'd0, HDR_MIN_BYTES})
               || (fin.meta.count < {10'd0, fin.meta.hdr_bytes})
               || (fin.meta.count < fin.meta.total_len)
               || ((cls_c != CLS_OTHER) && ({1'b0, fin.meta.count} < end_c));
  end

  always_comb begin
    l4_raw   = s2_pseudo_r ? oc_add(s2_psum_r, s2_len_r) : s2_psum_r;
    l4_sum_c = (s2_cls_r == CLS_OTHER) ? '0 : ~l4_raw;
    ip_ok_c  = (s2_shc_r == s2_ip_sum_r);
    l4_ok_c  = (s2_cls_r != CLS_OTHER) && (s2_spc_r == l4_sum_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v_r <= fin_valid;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && fin_valid) begin
      s2_ip_sum_r <= ~fin.hdr_sum;
      s2_shc_r    <= fin.meta.stored_hdr;
      s2_spc_r    <= fin.meta.stored_pay;
      s2_psum_r   <= psum_c;
      s2_len_r    <= len_c;
      s2_cls_r    <= cls_c;
      s2_pseudo_r <= pseudo_c;
      s2_trunc_r  <= trunc_c;
    end
    if (out_free && s2_v_r) begin
      out_ip_sum_r <= s2_ip_sum_r;
      out_l4_sum_r <= l4_sum_c;
      out_cls_r    <= s2_cls_r;
      out_ip_ok_r  <= ip_ok_c;
      out_l4_ok_r  <= l4_ok_c;
      out_trunc_r  <= s2_trunc_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.ip_sum      = out_ip_sum_r;
  assign out_ch.l4_sum      = out_l4_sum_r;
  assign out_ch.proto_class = out_cls_r;
  assign out_ch.ip_ok       = out_ip_ok_r;
  assign out_ch.l4_ok       = out_l4_ok_r;
  assign out_ch.packet_ok   = out_ip_ok_r && out_l4_ok_r;
  assign out_ch.truncated   = out_trunc_r;

endmodule
`default_nettype wire
